[hw/rtl/spf_pkg.sv]
// shared constants, types and helpers for the sphere penalty force block
package spf_pkg;

    localparam int unsigned POS_W    = 16;
    localparam int unsigned RAD_W    = 15;
    localparam int unsigned STIFF_W  = 16;
    localparam int unsigned FORCE_W  = 24;
    localparam int unsigned SQ_W     = 34;   // sum of three squares of 16-bit values
    localparam int unsigned LEN_W    = 17;   // floor sqrt of a 34-bit value
    localparam int unsigned MAG_W    = 16;   // magnitude of a 16-bit coordinate
    localparam int unsigned GAIN_W   = 31;   // stiffness * (radius - length)
    localparam int unsigned NUM_W    = 47;   // gain * magnitude
    localparam int unsigned ADDR_W   = 3;

    localparam logic [ADDR_W-1:0] ADDR_RADIUS = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_STIFF  = 3'd4;

    localparam logic [NUM_W-1:0] FORCE_MAX_POS = NUM_W'(23'h7FFFFF);
    localparam logic [NUM_W-1:0] FORCE_MAX_NEG = NUM_W'(24'h800000);

    // per item control that travels down the pipe
    typedef struct packed {
        logic                vld;
        logic                in_sphere;
        logic                zero_len;
        logic [2:0]          neg;
    } spf_ctl_t;

endpackage

[hw/rtl/sphere_penalty_force.sv]
// top level of the sphere penalty force pipeline
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  command   | pos_x, pos_y, pos_z                       | start & !busy
//  result    | force_x/y/z, inside_res, saturated        | done strobe, one cycle
//  config    | psel penable pwrite paddr pwdata prdata   | apb, pready tied high
//
//  one transaction per cycle; busy is always low
//  done is registered after the capture and square stage and
//  1 (sum), 18 (square root), 2, 48 (divider) and 1 (output) register stages
//  the divider stages, one quotient bit each, set the depth
//  reset clears radius, stiffness and all valid bits
//  no stall exists: the pipe advances every cycle
module sphere_penalty_force
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [spf_pkg::POS_W-1:0]    pos_x,
    input  logic signed [spf_pkg::POS_W-1:0]    pos_y,
    input  logic signed [spf_pkg::POS_W-1:0]    pos_z,
    output logic                                done,
    output logic signed [spf_pkg::FORCE_W-1:0]  force_x,
    output logic signed [spf_pkg::FORCE_W-1:0]  force_y,
    output logic signed [spf_pkg::FORCE_W-1:0]  force_z,
    output logic                                inside_res,
    output logic                                saturated,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spf_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int unsigned PW = spf_pkg::POS_W;
    localparam int unsigned NW = spf_pkg::NUM_W;
    localparam int unsigned LW = spf_pkg::LEN_W;
    localparam int unsigned FW = spf_pkg::FORCE_W;

    function automatic logic [spf_pkg::MAG_W-1:0] MAG_W_NEG(input logic [PW-1:0] v);
        logic [PW-1:0] n;
        n = ~v + PW'(1);
        return n;
    endfunction

    logic [spf_pkg::RAD_W-1:0]   radius_reg;
    logic [spf_pkg::STIFF_W-1:0] stiffness_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= '0;
            stiffness_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == spf_pkg::ADDR_RADIUS)
            begin
                radius_reg <= pwdata[spf_pkg::RAD_W-1:0];
            end
            else if (paddr == spf_pkg::ADDR_STIFF)
            begin
                stiffness_reg <= pwdata[spf_pkg::STIFF_W-1:0];
            end
        end
    end

    // register read back
    always_comb
    begin
        case (paddr)
            spf_pkg::ADDR_RADIUS: prdata = 32'(radius_reg);
            spf_pkg::ADDR_STIFF:  prdata = 32'(stiffness_reg);
            default:              prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // stage a: capture and square
    logic                 a_vld_reg;
    logic [PW-1:0]        a_pos_reg [3];
    logic [2*PW-1:0]      a_sqx_reg, a_sqy_reg, a_sqz_reg;
    logic signed [2*PW-1:0] x_ext, y_ext, z_ext;

    assign x_ext = {{PW{pos_x[PW-1]}}, pos_x};
    assign y_ext = {{PW{pos_y[PW-1]}}, pos_y};
    assign z_ext = {{PW{pos_z[PW-1]}}, pos_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pos_reg[0] <= pos_x;
        a_pos_reg[1] <= pos_y;
        a_pos_reg[2] <= pos_z;
        a_sqx_reg    <= x_ext * x_ext;
        a_sqy_reg    <= y_ext * y_ext;
        a_sqz_reg    <= z_ext * z_ext;
    end

    // stage b: sum of squares
    logic                   b_vld_reg;
    logic [spf_pkg::SQ_W-1:0] b_sq_reg;
    logic [3*PW-1:0]        b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_sq_reg   <= spf_pkg::SQ_W'(a_sqx_reg) + spf_pkg::SQ_W'(a_sqy_reg)
                    + spf_pkg::SQ_W'(a_sqz_reg);
        b_side_reg <= {a_pos_reg[0], a_pos_reg[1], a_pos_reg[2]};
    end

    // length
    logic            r_vld;
    logic [LW-1:0]   r_len;
    logic [3*PW-1:0] r_side;

    spf_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (b_vld_reg),
        .in_sq    (b_sq_reg),
        .in_side  (b_side_reg),
        .out_vld  (r_vld),
        .out_len  (r_len),
        .out_side (r_side)
    );

    // stage c: compare with radius, gain, magnitudes
    logic             c_vld_reg;
    spf_pkg::spf_ctl_t c_ctl_reg;
    logic [spf_pkg::GAIN_W-1:0] c_gain_reg;
    logic [spf_pkg::MAG_W-1:0]  c_mag_reg [3];
    logic [LW-1:0]    c_len_reg;
    logic [PW-1:0]    r_pos [3];
    logic [LW-1:0]    r_diff;
    logic             r_inside;

    assign r_pos[0] = r_side[3*PW-1:2*PW];
    assign r_pos[1] = r_side[2*PW-1:PW];
    assign r_pos[2] = r_side[PW-1:0];
    assign r_inside = r_len <= LW'(radius_reg);
    assign r_diff   = LW'(radius_reg) - r_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        c_ctl_reg.vld       <= 1'b1;
        c_ctl_reg.in_sphere <= r_inside;
        c_ctl_reg.zero_len  <= r_len == '0;
        c_gain_reg <= r_inside ? spf_pkg::GAIN_W'(stiffness_reg)
                                 * spf_pkg::GAIN_W'(r_diff[spf_pkg::RAD_W-1:0])
                               : '0;
        c_len_reg  <= (r_len == '0) ? LW'(1) : r_len;
        for (int l = 0; l < 3; l++)
        begin
            c_ctl_reg.neg[l] <= r_pos[l][PW-1];
            c_mag_reg[l]     <= r_pos[l][PW-1] ? MAG_W_NEG(r_pos[l]) : r_pos[l];
        end
    end

    // stage d: numerators
    logic             d_vld_reg;
    spf_pkg::spf_ctl_t d_ctl_reg;
    logic [NW-1:0]    d_num_reg [3];
    logic [LW-1:0]    d_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_ctl_reg <= c_ctl_reg;
        d_len_reg <= c_len_reg;
        for (int l = 0; l < 3; l++)
        begin
            d_num_reg[l] <= NW'(c_gain_reg) * NW'(c_mag_reg[l]);
        end
    end

    // quotients
    spf_pkg::spf_ctl_t q_ctl;
    logic [NW-1:0]    q_quo [3];

    spf_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (d_vld_reg),
        .in_ctl  (d_ctl_reg),
        .in_num  (d_num_reg),
        .in_den  (d_len_reg),
        .out_ctl (q_ctl),
        .out_quo (q_quo)
    );

    // stage e: sign, saturation, output register
    logic [FW-1:0] sat_val [3];
    logic [2:0]    sat_hit;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (q_ctl.neg[l])
            begin
                sat_hit[l] = q_quo[l] > spf_pkg::FORCE_MAX_NEG;
                sat_val[l] = sat_hit[l] ? FW'(24'h800000) : FW'(~q_quo[l] + NW'(1));
            end
            else
            begin
                sat_hit[l] = q_quo[l] > spf_pkg::FORCE_MAX_POS;
                sat_val[l] = sat_hit[l] ? FW'(24'h7FFFFF) : FW'(q_quo[l]);
            end
        end
    end

    logic       done_reg;
    logic [FW-1:0] fx_reg, fy_reg, fz_reg;
    logic       ins_reg, sat_reg;
    logic       live;

    assign live = q_ctl.in_sphere && !q_ctl.zero_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= q_ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg  <= live ? sat_val[0] : '0;
        fy_reg  <= live ? sat_val[1] : '0;
        fz_reg  <= live ? sat_val[2] : '0;
        ins_reg <= q_ctl.in_sphere;
        sat_reg <= live && (sat_hit != 3'b000);
    end

    assign done       = done_reg;
    assign force_x    = fx_reg;
    assign force_y    = fy_reg;
    assign force_z    = fz_reg;
    assign inside_res = ins_reg;
    assign saturated  = sat_reg;

endmodule

[hw/rtl/spf_div.sv]
// pipelined restoring divider, one quotient bit per stage, three lanes share the divisor
module spf_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  spf_pkg::spf_ctl_t                 in_ctl,
    input  logic [spf_pkg::NUM_W-1:0]         in_num [3],
    input  logic [spf_pkg::LEN_W-1:0]         in_den,
    output spf_pkg::spf_ctl_t                 out_ctl,
    output logic [spf_pkg::NUM_W-1:0]         out_quo [3]
);

    localparam int unsigned NW = spf_pkg::NUM_W;
    localparam int unsigned DW = spf_pkg::LEN_W;

    spf_pkg::spf_ctl_t         ctl_reg  [NW+1];
    logic [NW-1:0]             quo_reg  [NW+1][3];
    logic [DW:0]               rem_reg  [NW+1][3];
    logic [DW-1:0]             den_reg  [NW+1];

    // stage 0 loads the operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= '{vld: in_vld, in_sphere: in_ctl.in_sphere,
                            zero_len: in_ctl.zero_len, neg: in_ctl.neg};
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= in_den;
        for (int l = 0; l < 3; l++)
        begin
            quo_reg[0][l] <= in_num[l];
            rem_reg[0][l] <= '0;
        end
    end

    // one shift and subtract per stage, numerator bits shift out of the quotient word
    for (genvar s = 0; s < NW; s++)
    begin : g_stage
        logic [DW:0]   rem_next [3];
        logic [NW-1:0] quo_next [3];
        logic [DW+1:0] trial    [3];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {rem_reg[s][l], quo_reg[s][l][NW-1]} - {2'b00, den_reg[s]};
                if (!trial[l][DW+1])
                begin
                    rem_next[l] = trial[l][DW:0];
                    quo_next[l] = {quo_reg[s][l][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = {rem_reg[s][l][DW-1:0], quo_reg[s][l][NW-1]};
                    quo_next[l] = {quo_reg[s][l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_reg[s];
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[s+1][l] <= rem_next[l];
                quo_reg[s+1][l] <= quo_next[l];
            end
        end
    end

    assign out_ctl = ctl_reg[NW];
    assign out_quo = quo_reg[NW];

endmodule

[hw/rtl/spf_sqrt.sv]
// pipelined integer square root, one root bit per stage
module spf_sqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic [spf_pkg::SQ_W-1:0]          in_sq,
    input  logic [3*spf_pkg::POS_W-1:0]       in_side,
    output logic                              out_vld,
    output logic [spf_pkg::LEN_W-1:0]         out_len,
    output logic [3*spf_pkg::POS_W-1:0]       out_side
);

    localparam int unsigned SW = spf_pkg::SQ_W;
    localparam int unsigned RW = spf_pkg::LEN_W;
    localparam int unsigned SIDE_W = 3 * spf_pkg::POS_W;

    logic              vld_reg  [RW+1];
    logic [SW-1:0]     rad_reg  [RW+1];
    logic [RW+1:0]     rem_reg  [RW+1];
    logic [RW-1:0]     root_reg [RW+1];
    logic [SIDE_W-1:0] side_reg [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0]  <= in_sq;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        side_reg[0] <= in_side;
    end

    // digit by digit root, two radicand bits enter each stage
    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic [RW+1:0] rem_next;
        logic [RW-1:0] root_next;

        always_comb
        begin
            rem_sh = {rem_reg[s][RW-1:0], rad_reg[s][SW-1:SW-2]};
            trial  = {root_reg[s], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[s][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[s][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[s+1]  <= {rad_reg[s][SW-3:0], 2'b00};
            rem_reg[s+1]  <= rem_next;
            root_reg[s+1] <= root_next;
            side_reg[s+1] <= side_reg[s];
        end
    end

    assign out_vld  = vld_reg[RW];
    assign out_len  = root_reg[RW];
    assign out_side = side_reg[RW];

endmodule

[hw/rtl/sphere_penalty_force_chk.sv]
// port level checker for the sphere penalty force block
module sphere_penalty_force_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic        pready,
    input logic        inside_res,
    input logic        saturated,
    input logic [23:0] force_x,
    input logic [23:0] force_y,
    input logic [23:0] force_z
);

    // the pipe never holds off a command
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // an outside result carries no force
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !inside_res) |-> (force_x == '0 && force_y == '0 && force_z == '0))
        else $error("force outside sphere");

    // saturation only inside
    a_sat_in: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> inside_res)
        else $error("saturation flagged outside");

endmodule

bind sphere_penalty_force sphere_penalty_force_chk u_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .done       (done),
    .pready     (pready),
    .inside_res (inside_res),
    .saturated  (saturated),
    .force_x    (force_x),
    .force_y    (force_y),
    .force_z    (force_z)
);
